@@ rtl/direct_mapped_writeback_cache_defines.svh @@
// assertion macros for the cache block
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_DEFINES_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define DMWC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cache check failed: same-cycle implication");
// next-cycle implication
`define DMWC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cache check failed: next-cycle implication");
`else
`define DMWC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define DMWC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/dmwc_pkg.sv @@
package dmwc_pkg;

  localparam int BYTE_ADDR_W = 18;
  localparam int WORD_ADDR_W = 16;
  localparam int DATA_W      = 32;
  localparam int LAT_W       = 10;
  localparam int COST_W      = 12;
  localparam int COUNT_W     = 32;
  localparam int TOTAL_CYC_W = 48;

  localparam int NUM_LINES_DEF      = 64;
  localparam int WORDS_PER_LINE_DEF = 4;
  localparam int MEMORY_WORDS_DEF   = 65536;

  localparam logic [LAT_W-1:0]  LATENCY_RESET = 10'd100;
  localparam logic [COST_W-1:0] BASE_CYCLES   = 12'd2;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_COMPARE,
    ST_SPILL,
    ST_FILL,
    ST_ACCESS,
    ST_DONE
  } dmwc_state_t;

  // controller to datapath
  typedef struct packed {
    logic clear;    // zero one backing word
    logic accept;   // ready for a request beat
    logic lookup;   // read tag store
    logic decide;   // resolve hit or miss, update tag and valid
    logic spill;    // victim line to backing memory
    logic fill;     // backing memory to line
    logic access;   // word read or write in the line
    logic load;     // load the response register
  } dmwc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic in_valid;
    logic hit;
    logic victim;
    logic need_fill;
    logic fill_flag;
    logic xfer_last;
    logic out_free;
  } dmwc_stat_t;

endpackage

@@ rtl/dmwc_channels.sv @@
interface dmwc_req_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   mode;
  logic [dmwc_pkg::BYTE_ADDR_W-1:0]       byte_address;
  logic [dmwc_pkg::DATA_W-1:0]            write_data;

  modport source (output valid, mode, byte_address, write_data, input ready);
  modport sink   (input valid, mode, byte_address, write_data, output ready);
endinterface

interface dmwc_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   hit;
  logic [dmwc_pkg::DATA_W-1:0]            read_data;
  logic                                   wrote_back;
  logic [dmwc_pkg::COST_W-1:0]            access_cycles;
  logic [dmwc_pkg::COUNT_W-1:0]           total_accesses;
  logic [dmwc_pkg::COUNT_W-1:0]           total_misses;
  logic [dmwc_pkg::TOTAL_CYC_W-1:0]       total_cycles;

  modport source (output valid, hit, read_data, wrote_back, access_cycles,
                  total_accesses, total_misses, total_cycles, input ready);
  modport sink   (input valid, hit, read_data, wrote_back, access_cycles,
                  total_accesses, total_misses, total_cycles, output ready);
endinterface

@@ rtl/dmwc_ram.sv @@
module dmwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/dmwc_ctrl.sv @@
module dmwc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  dmwc_pkg::dmwc_stat_t  stat,
  output dmwc_pkg::dmwc_cmd_t   cmd
);

  dmwc_pkg::dmwc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmwc_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dmwc_pkg::ST_CLEAR: begin
        if (stat.clear_last) state_next = dmwc_pkg::ST_IDLE;
      end
      dmwc_pkg::ST_IDLE: begin
        if (stat.in_valid) state_next = dmwc_pkg::ST_LOOKUP;
      end
      dmwc_pkg::ST_LOOKUP: begin
        state_next = dmwc_pkg::ST_COMPARE;
      end
      dmwc_pkg::ST_COMPARE: begin
        if (stat.hit) state_next = dmwc_pkg::ST_ACCESS;
        else if (stat.victim) state_next = dmwc_pkg::ST_SPILL;
        else if (stat.need_fill) state_next = dmwc_pkg::ST_FILL;
        else state_next = dmwc_pkg::ST_ACCESS;
      end
      dmwc_pkg::ST_SPILL: begin
        if (stat.xfer_last) begin
          state_next = stat.fill_flag ? dmwc_pkg::ST_FILL : dmwc_pkg::ST_ACCESS;
        end
      end
      dmwc_pkg::ST_FILL: begin
        if (stat.xfer_last) state_next = dmwc_pkg::ST_ACCESS;
      end
      dmwc_pkg::ST_ACCESS: begin
        state_next = dmwc_pkg::ST_DONE;
      end
      dmwc_pkg::ST_DONE: begin
        if (stat.out_free) state_next = dmwc_pkg::ST_IDLE;
      end
      default: begin
        state_next = dmwc_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      dmwc_pkg::ST_CLEAR:   cmd.clear  = 1'b1;
      dmwc_pkg::ST_IDLE:    cmd.accept = 1'b1;
      dmwc_pkg::ST_LOOKUP:  cmd.lookup = 1'b1;
      dmwc_pkg::ST_COMPARE: cmd.decide = 1'b1;
      dmwc_pkg::ST_SPILL:   cmd.spill  = 1'b1;
      dmwc_pkg::ST_FILL:    cmd.fill   = 1'b1;
      dmwc_pkg::ST_ACCESS:  cmd.access = 1'b1;
      dmwc_pkg::ST_DONE:    cmd.load   = stat.out_free;
      default:              cmd = '0;
    endcase
  end

endmodule

@@ rtl/dmwc_datapath.sv @@
module dmwc_datapath #(
  parameter int NUM_LINES      = dmwc_pkg::NUM_LINES_DEF,
  parameter int WORDS_PER_LINE = dmwc_pkg::WORDS_PER_LINE_DEF,
  parameter int MEMORY_WORDS   = dmwc_pkg::MEMORY_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  dmwc_req_if.sink                      req,
  dmwc_rsp_if.source                    rsp,
  input  logic                          cfg_we,
  input  logic [dmwc_pkg::LAT_W-1:0]    cfg_wdata,
  input  dmwc_pkg::dmwc_cmd_t           cmd,
  output dmwc_pkg::dmwc_stat_t          stat
);

  localparam int AW         = dmwc_pkg::WORD_ADDR_W;
  localparam int DW         = dmwc_pkg::DATA_W;
  localparam int CW         = dmwc_pkg::COST_W;
  localparam int NW         = dmwc_pkg::COUNT_W;
  localparam int TW         = dmwc_pkg::TOTAL_CYC_W;
  localparam int OFF_BITS   = $clog2(WORDS_PER_LINE);
  localparam int OFF_W      = OFF_BITS > 0 ? OFF_BITS : 1;
  localparam int SET_BITS   = $clog2(NUM_LINES);
  localparam int SET_W      = SET_BITS > 0 ? SET_BITS : 1;
  localparam int TAG_BITS   = AW - OFF_BITS - SET_BITS;
  localparam int TAG_W      = TAG_BITS > 0 ? TAG_BITS : 1;
  localparam int LINE_DEPTH = NUM_LINES * WORDS_PER_LINE;
  localparam int LINE_W     = LINE_DEPTH > 1 ? $clog2(LINE_DEPTH) : 1;
  localparam int MEM_AW     = $clog2(MEMORY_WORDS);
  localparam int XFER_W     = $clog2(WORDS_PER_LINE + 1);

  // request registers
  logic                        mode;
  logic [AW-1:0]               waddr;
  logic [DW-1:0]               write_data;
  logic [dmwc_pkg::LAT_W-1:0]  memory_latency;

  logic [NUM_LINES-1:0]        line_valid;
  logic                        hit_flag;
  logic                        victim_flag;
  logic                        fill_flag;
  logic [TAG_W-1:0]            victim_tag;

  logic [XFER_W-1:0]           xfer_count;
  logic                        xfer_pend;
  logic [OFF_W-1:0]            xfer_word;
  logic [MEM_AW-1:0]           clear_addr;

  logic                        out_valid;
  logic [NW-1:0]               access_count;
  logic [NW-1:0]               miss_total;
  logic [TW-1:0]               cycle_count;

  // address decode
  logic [AW-1:0]     line_addr;
  logic [AW-1:0]     tag_full;
  logic [SET_W-1:0]  set_idx;
  logic [TAG_W-1:0]  tag;
  logic [OFF_W-1:0]  offset;
  logic [AW-1:0]     fill_base;
  logic [AW-1:0]     victim_base;
  logic [OFF_W-1:0]  xfer_idx;
  logic              xfer_last;
  logic              xfer_active;
  logic              hit;

  // ram ports
  logic [TAG_W-1:0]  tag_q;
  logic              line_we;
  logic [LINE_W-1:0] line_waddr;
  logic [DW-1:0]     line_wdata;
  logic              line_re;
  logic [LINE_W-1:0] line_raddr;
  logic [DW-1:0]     line_q;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  logic [DW-1:0]     mem_wdata;
  logic              mem_re;
  logic [MEM_AW-1:0] mem_raddr;
  logic [DW-1:0]     mem_q;

  // result
  logic [CW-1:0]     cost;
  logic [NW-1:0]     access_count_next;
  logic [NW-1:0]     miss_total_next;
  logic [TW:0]       cycle_sum;
  logic [TW-1:0]     cycle_count_next;

  assign line_addr   = waddr >> OFF_BITS;
  assign tag_full    = waddr >> (OFF_BITS + SET_BITS);
  assign set_idx     = (SET_BITS == 0) ? '0 : line_addr[SET_W-1:0];
  assign tag         = tag_full[TAG_W-1:0];
  assign offset      = (OFF_BITS == 0) ? '0 : waddr[OFF_W-1:0];
  assign fill_base   = line_addr << OFF_BITS;
  assign victim_base = (AW'(victim_tag) << (OFF_BITS + SET_BITS))
                     | (AW'(set_idx) << OFF_BITS);
  assign xfer_idx    = (OFF_BITS == 0) ? '0 : xfer_count[OFF_W-1:0];
  assign xfer_last   = (xfer_count == XFER_W'(WORDS_PER_LINE));
  assign xfer_active = cmd.spill | cmd.fill;
  assign hit         = line_valid[set_idx] && (tag_q == tag);

  always_comb begin
    stat.clear_last = (clear_addr == MEM_AW'(MEMORY_WORDS - 1));
    stat.in_valid   = req.valid;
    stat.hit        = hit;
    stat.victim     = line_valid[set_idx];
    stat.need_fill  = (mode == dmwc_pkg::MODE_READ) || (WORDS_PER_LINE > 1);
    stat.fill_flag  = fill_flag;
    stat.xfer_last  = xfer_last;
    stat.out_free   = !out_valid || rsp.ready;
  end

  assign req.ready = cmd.accept;

  // request capture and config
  always_ff @(posedge clk) begin
    if (cmd.accept && req.valid) begin
      mode       <= req.mode;
      waddr      <= req.byte_address[dmwc_pkg::BYTE_ADDR_W-1:2];
      write_data <= req.write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      memory_latency <= dmwc_pkg::LATENCY_RESET;
    end else if (cfg_we) begin
      memory_latency <= cfg_wdata;
    end
  end

  // hit or miss resolution
  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= '0;
    end else if (cmd.decide && !hit) begin
      line_valid[set_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      hit_flag    <= hit;
      victim_flag <= !hit && line_valid[set_idx];
      fill_flag   <= !hit && stat.need_fill;
      victim_tag  <= tag_q;
    end
  end

  // word transfer sequencing: read in one cycle, write the next
  always_ff @(posedge clk) begin
    if (rst) begin
      xfer_count <= '0;
      xfer_pend  <= 1'b0;
      clear_addr <= '0;
    end else begin
      if (xfer_active && !xfer_last) begin
        xfer_count <= xfer_count + XFER_W'(1);
      end else begin
        xfer_count <= '0;
      end
      xfer_pend <= xfer_active && !xfer_last;
      if (cmd.clear) begin
        clear_addr <= clear_addr + MEM_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    xfer_word <= xfer_idx;
  end

  always_comb begin
    line_we    = 1'b0;
    line_waddr = (LINE_W'(set_idx) << OFF_BITS) | LINE_W'(xfer_word);
    line_wdata = mem_q;
    line_re    = 1'b0;
    line_raddr = (LINE_W'(set_idx) << OFF_BITS) | LINE_W'(xfer_idx);
    if (cmd.fill && xfer_pend) begin
      line_we = 1'b1;
    end else if (cmd.access && mode == dmwc_pkg::MODE_WRITE) begin
      line_we    = 1'b1;
      line_waddr = (LINE_W'(set_idx) << OFF_BITS) | LINE_W'(offset);
      line_wdata = write_data;
    end
    if (cmd.spill && !xfer_last) begin
      line_re = 1'b1;
    end else if (cmd.access && mode == dmwc_pkg::MODE_READ) begin
      line_re    = 1'b1;
      line_raddr = (LINE_W'(set_idx) << OFF_BITS) | LINE_W'(offset);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = MEM_AW'(victim_base + AW'(xfer_word));
    mem_wdata = line_q;
    if (cmd.clear) begin
      mem_we    = 1'b1;
      mem_waddr = clear_addr;
      mem_wdata = '0;
    end else if (cmd.spill && xfer_pend) begin
      mem_we = 1'b1;
    end
    mem_re    = cmd.fill && !xfer_last;
    mem_raddr = MEM_AW'(fill_base + AW'(xfer_idx));
  end

  dmwc_ram #(.WIDTH(TAG_W), .DEPTH(NUM_LINES)) u_tag_ram (
    .clk   (clk),
    .we    (cmd.decide && !hit),
    .waddr (set_idx),
    .wdata (tag),
    .re    (cmd.lookup),
    .raddr (set_idx),
    .rdata (tag_q)
  );

  dmwc_ram #(.WIDTH(DW), .DEPTH(LINE_DEPTH)) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .re    (line_re),
    .raddr (line_raddr),
    .rdata (line_q)
  );

  dmwc_ram #(.WIDTH(DW), .DEPTH(MEMORY_WORDS)) u_backing_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  // cost and saturating totals
  always_comb begin
    cost = dmwc_pkg::BASE_CYCLES
         + (victim_flag ? CW'(memory_latency) : '0)
         + (fill_flag   ? CW'(memory_latency) : '0);
    access_count_next = (access_count == '1) ? access_count : access_count + NW'(1);
    miss_total_next   = (hit_flag || miss_total == '1) ? miss_total
                                                       : miss_total + NW'(1);
    cycle_sum         = {1'b0, cycle_count} + (TW + 1)'(cost);
    cycle_count_next  = cycle_sum[TW] ? '1 : cycle_sum[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      access_count <= '0;
      miss_total   <= '0;
      cycle_count  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.load) begin
        access_count <= access_count_next;
        miss_total   <= miss_total_next;
        cycle_count  <= cycle_count_next;
        out_valid    <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rsp.hit            <= hit_flag;
      rsp.read_data      <= (mode == dmwc_pkg::MODE_WRITE) ? '0 : line_q;
      rsp.wrote_back     <= victim_flag;
      rsp.access_cycles  <= cost;
      rsp.total_accesses <= access_count_next;
      rsp.total_misses   <= miss_total_next;
      rsp.total_cycles   <= cycle_count_next;
    end
  end

  assign rsp.valid = out_valid;

endmodule

@@ rtl/direct_mapped_writeback_cache.sv @@
// direct-mapped write-back write-allocate cache with a zeroed backing memory
//
// req channel: one beat per access (mode, byte_address, write_data), taken
// when valid and ready are both high; ready is high only while idle.
// rsp channel: one beat per access with hit, read data, write-back flag,
// modeled cycle cost and the saturating running totals.
// cfg_we/cfg_wdata write memory_latency; write it only while idle.
//
// an access runs accept, lookup and compare, then a victim spill and a line
// refill where needed, then the word access and the response load; each
// transfer is one word a cycle through the backing ram
// reset: the backing memory is swept to zero one word a cycle, all MEMORY_WORDS
// words (65536 by default), with ready low; valid bits and totals clear at once
// stall: the response register holds while rsp.ready is low; the next request
// is still taken and runs up to its own response, then waits for the register
`include "direct_mapped_writeback_cache_defines.svh"

module direct_mapped_writeback_cache #(
  parameter int NUM_LINES      = dmwc_pkg::NUM_LINES_DEF,
  parameter int WORDS_PER_LINE = dmwc_pkg::WORDS_PER_LINE_DEF,
  parameter int MEMORY_WORDS   = dmwc_pkg::MEMORY_WORDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  dmwc_req_if.sink                    req,
  dmwc_rsp_if.source                  rsp,
  input  logic                        cfg_we,
  input  logic [dmwc_pkg::LAT_W-1:0]  cfg_wdata
);

  // command and status between sequencer and datapath
  dmwc_pkg::dmwc_cmd_t  cmd;
  dmwc_pkg::dmwc_stat_t stat;

  // sequencer: clear sweep, lookup, spill, fill, word access, response
  dmwc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // datapath: tag, line and backing rams, valid bits, totals, response register
  dmwc_datapath #(
    .NUM_LINES      (NUM_LINES),
    .WORDS_PER_LINE (WORDS_PER_LINE),
    .MEMORY_WORDS   (MEMORY_WORDS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat)
  );

  // one access in flight: no second beat right after an accept
  `DMWC_ASSERT_NEXT(a_one_in_flight, clk, rst, req.valid && req.ready, !req.ready)
  // the response register is never overwritten while a beat waits
  `DMWC_ASSERT_IMPLY(a_no_overwrite, clk, rst, cmd.load, !rsp.valid || rsp.ready)
  // a response only appears after a load command
  `DMWC_ASSERT_IMPLY(a_rsp_from_load, clk, rst, $rose(rsp.valid), $past(cmd.load))
  // ram traffic phases never overlap
  `DMWC_ASSERT_IMPLY(a_phase_exclusive, clk, rst, 1'b1,
    $onehot0({cmd.clear, cmd.accept, cmd.spill, cmd.fill, cmd.access}))

endmodule

@@ test/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dmwc_pkg::*;

  // address split of the default geometry
  localparam int OFF_W = $clog2(WORDS_PER_LINE_DEF);
  localparam int SET_W = $clog2(NUM_LINES_DEF);
  localparam int TAG_W = WORD_ADDR_W - OFF_W - SET_W;

  // a write miss refills the line only when a line holds more than one word
  localparam bit FILL_ON_WRITE = (WORDS_PER_LINE_DEF > 1);

  // timing budget: sweep of the backing ram plus a slow run, several times over
  localparam int unsigned LIMIT_CYCLES = 600000;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct packed {
    logic                   hit;
    logic [DATA_W-1:0]      read_data;
    logic                   wrote_back;
    logic [COST_W-1:0]      access_cycles;
    logic [COUNT_W-1:0]     total_accesses;
    logic [COUNT_W-1:0]     total_misses;
    logic [TOTAL_CYC_W-1:0] total_cycles;
  } cache_result_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [LAT_W-1:0] cfg_wdata;

  dmwc_req_if req_ch ();
  dmwc_rsp_if rsp_ch ();

  direct_mapped_writeback_cache uut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // shadow copy of the cache and its backing memory
  logic                   shadow_valid [NUM_LINES_DEF];
  logic [TAG_W-1:0]       shadow_tag   [NUM_LINES_DEF];
  logic [DATA_W-1:0]      shadow_words [NUM_LINES_DEF*WORDS_PER_LINE_DEF];
  logic [DATA_W-1:0]      shadow_mem   [MEMORY_WORDS_DEF];
  logic [COUNT_W-1:0]     shadow_accesses;
  logic [COUNT_W-1:0]     shadow_misses;
  logic [TOTAL_CYC_W-1:0] shadow_cycles;
  logic [LAT_W-1:0]       shadow_latency;

  // responses still owed by the block, oldest first
  cache_result_t pending_results[$];

  int unsigned fail_count;
  int unsigned sent_count;
  int unsigned beats_checked;
  int unsigned hits_seen;
  int unsigned spills_seen;
  int unsigned latency_writes;
  int unsigned cycle_count;

  // knobs for the stimulus and the response side
  bit               idling_on;
  bit               hold_rsp;
  logic [TAG_W-1:0] tag_pool [3];
  logic [SET_W-1:0] set_base;

  // clock: 10 ns period
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: counts every rising edge and gives up at the limit
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d responses outstanding",
             cycle_count, pending_results.size());
    $display("** direct_mapped_writeback_cache: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // shadow model: one access in, the response it must produce out
  // ---------------------------------------------------------------------------

  function automatic cache_result_t predict_access(input logic mode,
                                                   input logic [BYTE_ADDR_W-1:0] addr,
                                                   input logic [DATA_W-1:0] data);
    cache_result_t          res;
    logic [WORD_ADDR_W-1:0] waddr;
    logic [OFF_W-1:0]       off;
    logic [SET_W-1:0]       set_idx;
    logic [TAG_W-1:0]       tag;
    logic [TOTAL_CYC_W-1:0] cyc_max;
    int unsigned            cost;
    res     = '0;
    waddr   = addr[BYTE_ADDR_W-1:2];
    off     = waddr[OFF_W-1:0];
    set_idx = waddr[OFF_W +: SET_W];
    tag     = waddr[WORD_ADDR_W-1 -: TAG_W];
    cost    = BASE_CYCLES;
    cyc_max = '1;
    if (shadow_valid[set_idx] && shadow_tag[set_idx] == tag) begin
      res.hit = 1'b1;
    end else begin
      // no dirty bit: any valid victim goes back to memory
      if (shadow_valid[set_idx]) begin
        for (int i = 0; i < WORDS_PER_LINE_DEF; i++) begin
          shadow_mem[{shadow_tag[set_idx], set_idx, i[OFF_W-1:0]}] =
            shadow_words[{set_idx, i[OFF_W-1:0]}];
        end
        res.wrote_back = 1'b1;
        cost += shadow_latency;
      end
      if (mode == MODE_READ || FILL_ON_WRITE) begin
        for (int i = 0; i < WORDS_PER_LINE_DEF; i++) begin
          shadow_words[{set_idx, i[OFF_W-1:0]}] = shadow_mem[{tag, set_idx, i[OFF_W-1:0]}];
        end
        cost += shadow_latency;
      end
      shadow_valid[set_idx] = 1'b1;
      shadow_tag[set_idx]   = tag;
      if (shadow_misses != '1) shadow_misses++;
    end
    if (mode == MODE_WRITE) shadow_words[{set_idx, off}] = data;
    else                    res.read_data = shadow_words[{set_idx, off}];
    if (shadow_accesses != '1) shadow_accesses++;
    if (cyc_max - shadow_cycles < cost) shadow_cycles = cyc_max;
    else                                shadow_cycles += cost;
    res.access_cycles  = cost[COST_W-1:0];
    res.total_accesses = shadow_accesses;
    res.total_misses   = shadow_misses;
    res.total_cycles   = shadow_cycles;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [BYTE_ADDR_W-1:0] addr_of(input logic [TAG_W-1:0] tag,
                                                     input logic [SET_W-1:0] set_idx,
                                                     input logic [OFF_W-1:0] off,
                                                     input logic [1:0] low);
    return {tag, set_idx, off, low};
  endfunction

  // mostly a few tags over a few sets so hits, refills and spills all show up
  function automatic logic [BYTE_ADDR_W-1:0] pick_address();
    logic [SET_W-1:0] s;
    s = set_base + SET_W'($urandom_range(0, 7));
    if ($urandom_range(0, 9) < 7)
      return addr_of(tag_pool[$urandom_range(0, 2)], s, OFF_W'($urandom_range(0, 3)),
                     2'($urandom_range(0, 3)));
    return BYTE_ADDR_W'($urandom_range(0, (1 << BYTE_ADDR_W) - 1));
  endfunction

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // one request beat; valid stays up afterwards so back-to-back beats need no gap
  task automatic send_access(input logic mode, input logic [BYTE_ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data);
    int unsigned gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid        <= 1'b1;
    req_ch.mode         <= mode;
    req_ch.byte_address <= addr;
    req_ch.write_data   <= data;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(predict_access(mode, addr, data));
    sent_count++;
  endtask

  // drop valid, let everything drain, then write the latency while idle
  task automatic set_memory_latency(input logic [LAT_W-1:0] value);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_latency = value;
    latency_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // response side: random stalls, one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        // long stretch with ready low so the block backs up into the request side
        hold_rsp = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // checker: every response beat against the oldest expectation
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [63:0] expv,
                             input logic [63:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, expv, actv);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    cache_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: response beat with nothing expected, expected none actual hit=%0h",
                 $time, rsp_ch.hit);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("hit",            64'(want.hit),            64'(rsp_ch.hit));
        check_field("read_data",      64'(want.read_data),      64'(rsp_ch.read_data));
        check_field("wrote_back",     64'(want.wrote_back),     64'(rsp_ch.wrote_back));
        check_field("access_cycles",  64'(want.access_cycles),  64'(rsp_ch.access_cycles));
        check_field("total_accesses", 64'(want.total_accesses), 64'(rsp_ch.total_accesses));
        check_field("total_misses",   64'(want.total_misses),   64'(rsp_ch.total_misses));
        check_field("total_cycles",   64'(want.total_cycles),   64'(rsp_ch.total_cycles));
        beats_checked++;
        if (want.hit) hits_seen++;
        if (want.wrote_back) spills_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hits, refills, spills and write allocation at the reset latency
  task automatic test_directed_basics();
    // cold read of set 0 returns the zeroed memory
    send_access(MODE_READ,  addr_of(0, 0, 0, 0), 32'h0);
    send_access(MODE_WRITE, addr_of(0, 0, 1, 0), '1);
    // low two address bits are don't-care
    send_access(MODE_READ,  addr_of(0, 0, 1, 3), 32'h1234_5678);
    send_access(MODE_WRITE, addr_of(0, 0, 0, 2), 32'h0);
    // conflict read: victim goes back, new tag refills
    send_access(MODE_READ,  addr_of(1, 0, 1, 0), 32'h0);
    // conflict back: the spilled word must come back from memory
    send_access(MODE_READ,  addr_of(0, 0, 1, 0), 32'h0);
    // write miss on an empty set still refills a multi-word line
    send_access(MODE_WRITE, addr_of(3, 5, 2, 1), 32'hDEAD_BEEF);
    send_access(MODE_WRITE, addr_of(200, 5, 3, 0), 32'hCAFE_F00D);
    send_access(MODE_READ,  addr_of(3, 5, 2, 0), 32'h0);
    send_access(MODE_READ,  addr_of(200, 5, 3, 0), 32'h0);
    // top of the address space, top tag and top set
    send_access(MODE_READ,  '1, 32'h0);
    send_access(MODE_WRITE, addr_of('1, '1, '1, 0), 32'hA5A5_A5A5);
    send_access(MODE_WRITE, addr_of(0, '1, 0, 0), 32'h5A5A_5A5A);
    send_access(MODE_READ,  '1, '1);
  endtask

  // smallest and largest memory latency, including the 2 + 2 * 1023 cost
  task automatic test_latency_extremes();
    set_memory_latency('0);
    send_access(MODE_READ,  addr_of(7, 9, 0, 0), 32'h0);
    send_access(MODE_READ,  addr_of(8, 9, 0, 0), 32'h0);
    send_access(MODE_WRITE, addr_of(8, 9, 2, 0), 32'h0F0F_0F0F);
    set_memory_latency('1);
    send_access(MODE_READ,  addr_of(7, 9, 0, 0), 32'h0);
    send_access(MODE_WRITE, addr_of(9, 9, 1, 0), 32'hF0F0_F0F0);
    send_access(MODE_WRITE, addr_of(9, 10, 1, 0), 32'h1111_2222);
    send_access(MODE_READ,  addr_of(9, 9, 1, 0), 32'h0);
  endtask

  // response side holds off while requests keep coming
  task automatic test_backpressure_fill();
    bit saved_idling;
    set_memory_latency(10'd37);
    saved_idling = idling_on;
    idling_on    = 1'b0;
    hold_rsp     = 1'b1;
    for (int i = 0; i < 16; i++) begin
      send_access(MODE_WRITE, addr_of(TAG_W'(i % 3), SET_W'(20 + i % 5), OFF_W'(i), 0),
                  pick_word());
    end
    idling_on = saved_idling;
  endtask

  task automatic test_random_traffic(input logic [LAT_W-1:0] latency, input int count,
                                     input bit idle);
    set_memory_latency(latency);
    idling_on = idle;
    set_base  = SET_W'($urandom_range(0, NUM_LINES_DEF - 1));
    for (int i = 0; i < 3; i++) tag_pool[i] = TAG_W'($urandom_range(0, (1 << TAG_W) - 1));
    for (int i = 0; i < count; i++) begin
      send_access(logic'($urandom_range(0, 1)), pick_address(), pick_word());
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    fail_count     = 0;
    sent_count     = 0;
    beats_checked  = 0;
    hits_seen      = 0;
    spills_seen    = 0;
    latency_writes = 0;
    idling_on      = 1'b1;
    hold_rsp       = 1'b0;

    req_ch.valid        = 1'b0;
    req_ch.mode         = MODE_READ;
    req_ch.byte_address = '0;
    req_ch.write_data   = '0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    rst                 = 1'b1;

    // shadow starts from the reset image
    for (int i = 0; i < NUM_LINES_DEF; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_tag[i]   = '0;
    end
    for (int i = 0; i < NUM_LINES_DEF * WORDS_PER_LINE_DEF; i++) shadow_words[i] = '0;
    for (int i = 0; i < MEMORY_WORDS_DEF; i++) shadow_mem[i] = '0;
    shadow_accesses = '0;
    shadow_misses   = '0;
    shadow_cycles   = '0;
    shadow_latency  = LATENCY_RESET;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // first beat waits out the memory sweep through ready
    test_directed_basics();
    test_latency_extremes();
    test_backpressure_fill();
    test_random_traffic('0, 150, 1'b1);
    test_random_traffic('1, 150, 1'b1);
    test_random_traffic(10'd1, 150, 1'b1);
    test_random_traffic(LAT_W'($urandom_range(2, 1022)), 150, 1'b1);
    // last stretch runs flat out on both sides
    test_random_traffic(LAT_W'($urandom_range(0, 1023)), 150, 1'b0);

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d accesses (%0d hits, %0d victim spills) over %0d latency settings,",
             sent_count, hits_seen, spills_seen, latency_writes + 1);
    $display("with random stalls on both channels and one long response hold-off");
    if (fail_count == 0) begin
      $display("** direct_mapped_writeback_cache: PASSED **");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("** direct_mapped_writeback_cache: FAILED **");
    end
    $finish;
  end

endmodule
